FILE: hw/rtl/assert_macros.svh
// Assertion macros for the RTL files of the flag unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: implication failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

`endif

FILE: hw/rtl/xafu_pkg.sv
// Types and constants of the x86 ALU flag unit.
`default_nettype none

package xafu_pkg;

    // Operation codes
    localparam logic [2:0] OP_ADD8  = 3'd0;
    localparam logic [2:0] OP_CMP8  = 3'd1;
    localparam logic [2:0] OP_CMP16 = 3'd2;
    localparam logic [2:0] OP_INC16 = 3'd3;
    localparam logic [2:0] OP_DEC16 = 3'd4;

    // Bit positions in the flags word
    localparam int FLAG_C_BIT = 0;
    localparam int FLAG_P_BIT = 2;
    localparam int FLAG_A_BIT = 4;
    localparam int FLAG_Z_BIT = 6;
    localparam int FLAG_S_BIT = 7;
    localparam int FLAG_O_BIT = 11;

    localparam logic [15:0] FLAG_MASK = 16'h08D5;

    localparam logic [15:0] INC_OVF_VALUE = 16'h7FFF;
    localparam logic [15:0] DEC_OVF_VALUE = 16'h8000;

    // Input item
    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] operand_a;
        logic [15:0] operand_b;
    } t_alu_in;

    // Result item
    typedef struct packed {
        logic [15:0] result;
        logic [15:0] flags;
    } t_alu_out;

    // Only the six status flags are ever written, so only they are kept
    typedef struct packed {
        logic of;
        logic sf;
        logic zf;
        logic af;
        logic pf;
        logic cf;
    } t_flag_bits;

    // Place the status flags at their 8086 positions
    function automatic logic [15:0] flags_to_word(input t_flag_bits f);
        logic [15:0] w;
        w = '0;
        w[FLAG_C_BIT] = f.cf;
        w[FLAG_P_BIT] = f.pf;
        w[FLAG_A_BIT] = f.af;
        w[FLAG_Z_BIT] = f.zf;
        w[FLAG_S_BIT] = f.sf;
        w[FLAG_O_BIT] = f.of;
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/x86_alu_flag_unit_core.sv
// Top level of the x86 ALU flag unit: 8086-style add, compare, inc and dec.
// An item passes from the input register to the result register, one item per
// cycle unless the output stalls; the kept flags word updates on that move,
// so no loop spans cycles.
// Reset (synchronous, active low) empties both registers and clears the flags.
`default_nettype none
`include "assert_macros.svh"

module x86_alu_flag_unit_core
    import xafu_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_alu_in  i_in_item,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_alu_out      o_out_item
);

    logic       r_s1_valid;
    t_alu_in    r_s1_item;
    logic       r_out_valid;
    t_alu_out   r_out_item;
    t_flag_bits r_flags;
    t_flag_bits n_flags;
    logic [15:0] n_result;

    logic out_free;
    logic s1_fire;
    logic in_fire;

    // Handshake: result register frees up when empty or taken
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_fire    = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_fire    = i_in_valid && !o_in_stall;

    // ALU and flag logic on the input register
    always_comb begin
        logic [7:0]  a8;
        logic [7:0]  b8;
        logic [8:0]  sum9;
        logic [8:0]  diff9;
        logic [16:0] diff17;
        logic [4:0]  nib_sum;
        logic [15:0] a16;
        logic [15:0] b16;
        logic        sign;
        logic        upd;
        a16      = r_s1_item.operand_a;
        b16      = r_s1_item.operand_b;
        a8       = a16[7:0];
        b8       = b16[7:0];
        sum9     = {1'b0, a8} + {1'b0, b8};
        diff9    = {1'b0, a8} - {1'b0, b8};
        diff17   = {1'b0, a16} - {1'b0, b16};
        nib_sum  = {1'b0, a16[3:0]} + {1'b0, b16[3:0]};
        n_flags  = r_flags;
        n_result = '0;
        sign     = 1'b0;
        upd      = 1'b1;
        case (r_s1_item.op)
            OP_ADD8: begin
                n_result   = {8'h00, sum9[7:0]};
                sign       = sum9[7];
                n_flags.cf = sum9[8];
                n_flags.af = nib_sum[4];
                n_flags.of = (a8[7] == b8[7]) && (sum9[7] != a8[7]);
            end
            OP_CMP8: begin
                n_result   = {8'h00, diff9[7:0]};
                sign       = diff9[7];
                n_flags.cf = diff9[8];
                n_flags.af = a16[3:0] < b16[3:0];
                n_flags.of = (a8[7] != b8[7]) && (diff9[7] != a8[7]);
            end
            OP_CMP16: begin
                n_result   = diff17[15:0];
                sign       = diff17[15];
                n_flags.cf = diff17[16];
                n_flags.af = a16[3:0] < b16[3:0];
                n_flags.of = (a16[15] != b16[15]) && (diff17[15] != a16[15]);
            end
            OP_INC16: begin
                n_result   = a16 + 16'd1;
                sign       = n_result[15];
                n_flags.af = a16[3:0] == 4'hF;
                n_flags.of = a16 == INC_OVF_VALUE;
            end
            OP_DEC16: begin
                n_result   = a16 - 16'd1;
                sign       = n_result[15];
                n_flags.af = a16[3:0] == 4'h0;
                n_flags.of = a16 == DEC_OVF_VALUE;
            end
            default: begin
                upd = 1'b0;
            end
        endcase
        // Zero, sign and parity are common to every valid operation
        if (upd) begin
            n_flags.zf = n_result == 16'h0000;
            n_flags.sf = sign;
            n_flags.pf = ~^n_result[7:0];
        end
    end

    // Control and kept flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
                r_flags     <= n_flags;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_item <= i_in_item;
        end
        if (s1_fire) begin
            r_out_item.result <= n_result;
            r_out_item.flags  <= flags_to_word(n_flags);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Checks
    `ASSERT_NEXT(a_flags_hold, i_clk, i_rst_n, !s1_fire, $stable(r_flags))
    `ASSERT_NEXT(a_carry_kept, i_clk, i_rst_n,
        s1_fire && (r_s1_item.op == OP_INC16 || r_s1_item.op == OP_DEC16),
        r_flags.cf == $past(r_flags.cf))
    `ASSERT_IMPLIES(a_reserved_zero, i_clk, i_rst_n, o_out_valid,
        (o_out_item.flags & ~FLAG_MASK) == 16'h0000)
    `ASSERT_IMPLIES(a_stall_needs_item, i_clk, i_rst_n, o_in_stall,
        r_s1_valid && r_out_valid)

endmodule

`default_nettype wire

FILE: tb/tb_x86_alu_flag_unit_core.sv
// Self-checking testbench for the x86 ALU flag unit: directed and random ops vs. a predictor.
`default_nettype none

module tb_x86_alu_flag_unit_core
    import xafu_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Op codes the block does not define; they leave the flags alone
    localparam logic [2:0] OP_RSVD5 = 3'd5;
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    localparam int RANDOM_ITEMS = 1450;
    localparam int DRAIN_AT     = 700;   // sender waits here for every result
    localparam int HOLD_AT      = 400;   // receiver holds off after this many results
    localparam int HOLD_CYCLES  = 90;
    localparam int TAIL_CYCLES  = 10;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     drv_valid = 1'b0;
    t_alu_in  drv_item = '0;
    logic     out_stall = 1'b0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_alu_out o_out_item;

    x86_alu_flag_unit_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (drv_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (drv_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item)
    );

    always #4 i_clk = ~i_clk;

    t_alu_in     pending_items[$];
    t_alu_out    expected_results[$];
    logic [15:0] kept_flags = '0;
    int          sent_count = 0;
    int          got_count = 0;
    int          taken_count = 0;
    int          mismatch_count = 0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    logic        hold_active = 1'b0;

    // Result and new flags word for one item; advances the kept flags
    function automatic t_alu_out alu_predict(input t_alu_in it);
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] r;
        logic [15:0] f;
        logic [8:0]  sum8;
        logic        wide;
        t_alu_out    o;
        a = it.operand_a;
        b = it.operand_b;
        r = '0;
        f = kept_flags;
        wide = 1'b1;
        case (it.op)
            OP_ADD8: begin
                sum8 = {1'b0, a[7:0]} + {1'b0, b[7:0]};
                r = {8'h00, sum8[7:0]};
                wide = 1'b0;
                f[FLAG_C_BIT] = sum8[8];
                f[FLAG_A_BIT] = ({1'b0, a[3:0]} + {1'b0, b[3:0]}) > 5'h0F;
                f[FLAG_O_BIT] = (a[7] == b[7]) && (r[7] != a[7]);
            end
            OP_CMP8: begin
                r = {8'h00, a[7:0] - b[7:0]};
                wide = 1'b0;
                f[FLAG_C_BIT] = a[7:0] < b[7:0];
                f[FLAG_A_BIT] = a[3:0] < b[3:0];
                f[FLAG_O_BIT] = (a[7] != b[7]) && (r[7] != a[7]);
            end
            OP_CMP16: begin
                r = a - b;
                f[FLAG_C_BIT] = a < b;
                f[FLAG_A_BIT] = a[3:0] < b[3:0];
                f[FLAG_O_BIT] = (a[15] != b[15]) && (r[15] != a[15]);
            end
            // inc and dec keep carry
            OP_INC16: begin
                r = a + 16'd1;
                f[FLAG_A_BIT] = a[3:0] == 4'hF;
                f[FLAG_O_BIT] = a == INC_OVF_VALUE;
            end
            OP_DEC16: begin
                r = a - 16'd1;
                f[FLAG_A_BIT] = a[3:0] == 4'h0;
                f[FLAG_O_BIT] = a == DEC_OVF_VALUE;
            end
            default: ;
        endcase
        // zero, sign and parity for every defined op
        if (it.op <= OP_DEC16) begin
            f[FLAG_Z_BIT] = r == 16'h0000;
            f[FLAG_S_BIT] = wide ? r[15] : r[7];
            f[FLAG_P_BIT] = ~^r[7:0];
        end
        kept_flags = f;
        o.result = r;
        o.flags = f;
        return o;
    endfunction

    function automatic t_alu_in alu_item(input logic [2:0] op, input logic [15:0] a,
                                         input logic [15:0] b);
        t_alu_in x;
        x.op = op;
        x.operand_a = a;
        x.operand_b = b;
        return x;
    endfunction

    // Operand with a bias toward sign, carry and nibble boundaries
    function automatic logic [15:0] pick_operand();
        logic [15:0] r;
        r = 16'($urandom);
        case ($urandom_range(0, 9))
            0: r = 16'h0000;
            1: r = 16'hFFFF;
            2: r = INC_OVF_VALUE;
            3: r = DEC_OVF_VALUE;
            4: r[7:0] = 8'h7F + 8'($urandom_range(0, 1));
            5: r[3:0] = {4{r[4]}};
            default: ;
        endcase
        return r;
    endfunction

    // Cycles to wait before the next item or result; none in quiet stretches
    function automatic int unsigned draw_wait(input bit quiet);
        if (quiet) return 0;
        case ($urandom_range(0, 3))
            0, 1: return 0;
            2: return $urandom_range(1, 3);
            default: return $urandom_range(0, 17);
        endcase
    endfunction

    // Sender: offers queued items, predicts each one as it is accepted
    always @(posedge i_clk) begin : driver
        logic    nv;
        t_alu_in ni;
        nv = drv_valid;
        ni = drv_item;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else begin
            if (drv_valid && !o_in_stall) begin
                expected_results.push_back(alu_predict(drv_item));
                sent_count++;
                nv = 1'b0;
                gap_left = draw_wait(((sent_count / 120) % 4 == 2) || hold_active);
            end
            if (!nv) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_items.size() > 0 &&
                             !(sent_count == DRAIN_AT && got_count != sent_count)) begin
                    ni = pending_items.pop_front();
                    nv = 1'b1;
                end
            end
        end
        drv_valid <= nv;
        drv_item <= ni;
    end

    // Receiver: random stall per result, plus one long hold-off
    always @(posedge i_clk) begin : receiver
        logic ns;
        ns = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && !out_stall) begin
                taken_count++;
                stall_left = draw_wait((taken_count / 150) % 4 == 1);
                if (taken_count == HOLD_AT) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                ns = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                ns = 1'b1;
            end
        end
        out_stall <= ns;
        hold_active <= (hold_left > 0);
    end

    // Checker: outputs are stable mid-cycle, so a result taken at the next
    // rising edge is compared at the falling edge before it
    always @(negedge i_clk) begin : monitor
        t_alu_out want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            got_count++;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %h", $time, o_out_item);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_out_item.result !== want.result) begin
                    $display("%0t: result mismatch: expected %h, actual %h",
                             $time, want.result, o_out_item.result);
                    mismatch_count++;
                end
                if (o_out_item.flags !== want.flags) begin
                    $display("%0t: flags mismatch: expected %h, actual %h",
                             $time, want.flags, o_out_item.flags);
                    mismatch_count++;
                end
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin : stimulus
        logic [2:0]  op;
        logic [15:0] a;
        logic [15:0] b;
        // add8: zero, carry, half carry, overflow; upper bytes ignored
        pending_items.push_back(alu_item(OP_ADD8, 16'h0000, 16'h0000));
        pending_items.push_back(alu_item(OP_ADD8, 16'hFFFF, 16'hFF01));
        pending_items.push_back(alu_item(OP_ADD8, 16'h007F, 16'h0001));
        pending_items.push_back(alu_item(OP_ADD8, 16'h0080, 16'h0080));
        pending_items.push_back(alu_item(OP_ADD8, 16'hAB0F, 16'h5501));
        // cmp8: equal, borrow, both overflow directions
        pending_items.push_back(alu_item(OP_CMP8, 16'h1255, 16'h3455));
        pending_items.push_back(alu_item(OP_CMP8, 16'h0000, 16'h0001));
        pending_items.push_back(alu_item(OP_CMP8, 16'h0080, 16'h0001));
        pending_items.push_back(alu_item(OP_CMP8, 16'h007F, 16'h00FF));
        // cmp16
        pending_items.push_back(alu_item(OP_CMP16, 16'hFFFF, 16'hFFFF));
        pending_items.push_back(alu_item(OP_CMP16, 16'h0000, 16'h0001));
        pending_items.push_back(alu_item(OP_CMP16, 16'h8000, 16'h0001));
        pending_items.push_back(alu_item(OP_CMP16, 16'h7FFF, 16'hFFFF));
        // inc16 with carry set from the compare above
        pending_items.push_back(alu_item(OP_INC16, 16'h7FFF, 16'h1234));
        pending_items.push_back(alu_item(OP_INC16, 16'hFFFF, 16'h0000));
        pending_items.push_back(alu_item(OP_INC16, 16'h000F, 16'hFFFF));
        // dec16
        pending_items.push_back(alu_item(OP_DEC16, 16'h8000, 16'h0000));
        pending_items.push_back(alu_item(OP_DEC16, 16'h0000, 16'hFFFF));
        pending_items.push_back(alu_item(OP_DEC16, 16'h0010, 16'h0000));
        pending_items.push_back(alu_item(OP_DEC16, 16'h0001, 16'h0000));
        // unused op codes keep the flags word and return zero
        pending_items.push_back(alu_item(OP_RSVD5, 16'hFFFF, 16'hFFFF));
        pending_items.push_back(alu_item(OP_RSVD6, 16'h1234, 16'h5678));
        pending_items.push_back(alu_item(OP_RSVD7, 16'h0000, 16'h8000));
        pending_items.push_back(alu_item(OP_ADD8, 16'h0001, 16'h00FF));
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 6)
                op = 3'($urandom_range(OP_RSVD5, OP_RSVD7));
            else
                op = 3'($urandom_range(OP_ADD8, OP_DEC16));
            a = pick_operand();
            b = pick_operand();
            // equal operands and zero sums now and then
            case ($urandom_range(0, 7))
                0: b = a;
                1: b = -a;
                default: ;
            endcase
            pending_items.push_back(alu_item(op, a, b));
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Done once nothing is queued or offered and every result has come;
        // checked mid-cycle so the sender's updates at the edge have settled
        @(negedge i_clk);
        while (pending_items.size() != 0 || drv_valid || got_count != sent_count) begin
            @(negedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Timeout
    initial begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
